@@ rtl/acd_pkg.sv @@
// Shared types, widths and constants of the astrocyte cell dynamics block.
`default_nettype none
package acd_pkg;

  localparam int ACD_TICK_WIDTH = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IP3_RETAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COVERED = 3'd4;

  localparam logic [15:0] RST_BASELINE = 16'd102;
  localparam logic [15:0] RST_TIME_STEP = 16'd66;
  localparam logic [15:0] RST_IP3_RETAIN = 16'd65208;
  localparam logic [15:0] RST_TARGET = 16'd19661;
  localparam logic [15:0] RST_COVERED = 16'd0;
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  localparam logic [15:0] CA_MAX = 16'd51200;
  localparam logic [14:0] IP3_MAX = 15'd20480;
  localparam logic [16:0] SCALE_MIN = 17'd16384;
  localparam logic [16:0] SCALE_MAX = 17'd65536;

  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 23;
  localparam int DIV_D_W = 5;

  localparam logic [DIV_D_W-1:0] DIV_BY_THREE = 5'd3;
  localparam logic [DIV_D_W-1:0] DIV_BY_FIVE = 5'd5;
  localparam logic [DIV_D_W-1:0] DIV_BY_TWENTYFIVE = 5'd25;

  typedef struct packed {
    logic               go;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } acd_mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] p;
  } acd_mul_rsp_t;

  typedef struct packed {
    logic               go;
    logic [DIV_N_W-1:0] n;
    logic [DIV_D_W-1:0] d;
  } acd_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] q;
  } acd_div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/acd_if.sv @@
// Stream interfaces for the input items and the result items.
`default_nettype none
interface acd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] stimulus;
  logic [15:0] activity_level;
  logic        release_request;
  logic [15:0] synapse_index;
  logic [15:0] synapse_strength;

  modport source (output valid, stimulus, activity_level, release_request, synapse_index,
                  synapse_strength, input ready);
  modport sink (input valid, stimulus, activity_level, release_request, synapse_index,
                synapse_strength, output ready);
endinterface

interface acd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] calcium_level;
  logic [14:0] ip3_level;
  logic [15:0] atp_out;
  logic        spike_flag;
  logic [31:0] spike_tick;
  logic [15:0] glutamate_amount;
  logic [15:0] d_serine_amount;
  logic [15:0] new_strength;
  logic [16:0] homeo_scale;

  modport source (output valid, calcium_level, ip3_level, atp_out, spike_flag, spike_tick,
                  glutamate_amount, d_serine_amount, new_strength, homeo_scale,
                  input ready);
  modport sink (input valid, calcium_level, ip3_level, atp_out, spike_flag, spike_tick,
                glutamate_amount, d_serine_amount, new_strength, homeo_scale,
                output ready);
endinterface
`default_nettype wire

@@ rtl/acd_ser_mul.sv @@
// Bit-serial signed by unsigned shift-and-add multiplier.
`default_nettype none
module acd_ser_mul (
  input  wire                  clk,
  input  wire                  rst,
  input  acd_pkg::acd_mul_req_t req,
  output acd_pkg::acd_mul_rsp_t rsp
);
  import acd_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_P_W-1:0] acc;
  logic [MUL_P_W-1:0] addend;
  logic [MUL_P_W-1:0] acc_next;

  assign addend   = b_q[MUL_B_W-1] ? {{MUL_B_W{a_q[MUL_A_W-1]}}, a_q} : '0;
  assign acc_next = {acc[MUL_P_W-2:0], 1'b0} + addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      a_q <= req.a;
      b_q <= req.b;
      acc <= '0;
    end else if (busy) begin
      b_q <= {b_q[MUL_B_W-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;
endmodule
`default_nettype wire

@@ rtl/acd_ser_div.sv @@
// Restoring divider that yields one quotient bit per cycle for small divisors.
`default_nettype none
module acd_ser_div (
  input  wire                  clk,
  input  wire                  rst,
  input  acd_pkg::acd_div_req_t req,
  output acd_pkg::acd_div_rsp_t rsp
);
  import acd_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_N_W-1:0] n_q;
  logic [DIV_D_W-1:0] d_q;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W:0]   trial;
  logic               fits;

  assign trial = {rem, n_q[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      n_q <= req.n;
      d_q <= req.d;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DIV_D_W'(trial - {1'b0, d_q}) : trial[DIV_D_W-1:0];
      n_q <= {n_q[DIV_N_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.q    = n_q;
endmodule
`default_nettype wire

@@ rtl/astrocyte_cell_dynamics_top.sv @@
// Top level of the astrocyte cell dynamics block: sequencer, state and registers.
`default_nettype none
// One tick of one cell per input transfer. The tick is worked out by a sequencer that
// drives one bit-serial multiplier and one bit-serial divider by a small constant, one
// operation after the other. The sequence is shortest without a stimulus above 2560 and
// without a valid release request, longer with only a high stimulus, and longest with
// both; the next input is taken in the cycle after the result has entered the output
// register, so a receiver that holds back the previous result also holds back the next
// input. Configuration writes take effect at once.
module astrocyte_cell_dynamics_top #(
  parameter int TICK_WIDTH = acd_pkg::ACD_TICK_WIDTH
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [acd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [acd_pkg::CFG_DATA_W-1:0]    cfg_data,
  acd_in_if.sink                           in_ch,
  acd_out_if.source                        out_ch
);
  import acd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CA   = 4'd1;
  localparam logic [3:0] ST_IP3A = 4'd2;
  localparam logic [3:0] ST_IP3D = 4'd3;
  localparam logic [3:0] ST_IP3R = 4'd4;
  localparam logic [3:0] ST_ATPM = 4'd5;
  localparam logic [3:0] ST_ATPD = 4'd6;
  localparam logic [3:0] ST_SCL  = 4'd7;
  localparam logic [3:0] ST_GLF  = 4'd8;
  localparam logic [3:0] ST_GLM  = 4'd9;
  localparam logic [3:0] ST_GLD  = 4'd10;
  localparam logic [3:0] ST_DS   = 4'd11;
  localparam logic [3:0] ST_STR  = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0] state;

  logic [15:0] base, dt, retain, target, covered;
  logic [15:0] ca;
  logic [14:0] ip3;
  logic [15:0] atp;
  logic [15:0] pool;
  logic [TICK_WIDTH-1:0] tick;
  logic [TICK_WIDTH-1:0] last_spike;

  logic signed [15:0] stim, act;
  logic        req_valid;
  logic [15:0] strength;

  logic        spike, div_neg;
  logic [15:0] glu, dser, newstr;
  logic [16:0] scale;

  logic        o_valid, o_spike;
  logic [15:0] o_ca, o_atp, o_glu, o_dser, o_str;
  logic [14:0] o_ip3;
  logic [31:0] o_tick;
  logic [16:0] o_scale;

  acd_mul_req_t mul_req;
  acd_mul_rsp_t mul_rsp;
  acd_div_req_t div_req;
  acd_div_rsp_t div_rsp;
  logic         mul_fire, div_fire;

  acd_ser_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  acd_ser_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic signed [MUL_P_W-1:0] mp;
  logic signed [21:0] ca_diff, s_ca;
  logic signed [24:0] ca_delta;
  logic signed [25:0] ca_sum;
  logic [15:0] ca_new;
  logic [17:0] base3, ca2;
  logic        spike_hit, stim_high;
  logic [17:0] ip3_sum;
  logic [14:0] ip3_cap;
  logic signed [23:0] atp_term, atp_n, atp_q;
  logic signed [24:0] atp_sum;
  logic [15:0] atp_new;
  logic [20:0] t5;
  logic signed [23:0] sc_n, sc_n2, sc_q, sc_sum;
  logic [16:0] scale_new;
  logic        ca_gt2, ds_hit;
  logic [16:0] gf_diff, ds_diff;
  logic [15:0] frac, dser_new;
  logic [34:0] x15;
  logic [63:0] last_ext;
  logic [15:0] str_new;

  assign mp       = $signed(mul_rsp.p);
  assign ca_diff  = $signed({6'b0, ca}) - $signed({6'b0, base});
  assign s_ca     = ($signed({{6{in_ch.stimulus[15]}}, in_ch.stimulus}) <<< 1)
                    - ((ca_diff <<< 3) + (ca_diff <<< 1));
  assign ca_delta = $signed(mp[40:16]);
  assign ca_sum   = $signed({10'b0, ca}) + $signed({ca_delta[24], ca_delta});
  always_comb begin
    if (ca_sum < 0) ca_new = 16'd0;
    else if (ca_sum > $signed({10'b0, CA_MAX})) ca_new = CA_MAX;
    else ca_new = ca_sum[15:0];
  end
  assign base3     = {2'b0, base} + {1'b0, base, 1'b0};
  assign spike_hit = {2'b0, ca_new} > base3;
  assign stim_high = stim > 16'sd2560;

  assign ip3_sum = {3'b0, ip3} + div_rsp.q[17:0];
  assign ip3_cap = (ip3_sum > {3'b0, IP3_MAX}) ? IP3_MAX : ip3_sum[14:0];

  assign atp_term = 24'sd163840 - ($signed({{8{act[15]}}, act}) <<< 7);
  assign atp_n    = $signed(mp[40:17]);
  assign atp_q    = div_neg ? ~$signed({1'b0, div_rsp.q}) : $signed({1'b0, div_rsp.q});
  assign atp_sum  = $signed({9'b0, atp}) + $signed({atp_q[23], atp_q});
  always_comb begin
    if (atp_sum < 0) atp_new = 16'd0;
    else if (atp_sum > $signed({9'b0, ONE_Q15})) atp_new = ONE_Q15;
    else atp_new = atp_sum[15:0];
  end

  assign t5     = {5'b0, target} + {3'b0, target, 2'b0};
  assign sc_n   = $signed({3'b0, t5}) - $signed({2'b0, ca, 6'b0});
  assign sc_n2  = sc_n >>> 2;
  assign sc_q   = div_neg ? ~$signed({1'b0, div_rsp.q}) : $signed({1'b0, div_rsp.q});
  assign sc_sum = 24'sd32768 + sc_q;
  always_comb begin
    if (sc_sum < $signed({7'b0, SCALE_MIN})) scale_new = SCALE_MIN;
    else if (sc_sum > $signed({7'b0, SCALE_MAX})) scale_new = SCALE_MAX;
    else scale_new = sc_sum[16:0];
  end

  assign ca_gt2   = {1'b0, ca} > {base, 1'b0};
  assign gf_diff  = {1'b0, ca} - {base, 1'b0};
  assign ca2      = {1'b0, ca, 1'b0};
  assign ds_hit   = ca2 > base3;
  assign ds_diff  = 17'(ca2 - base3);
  assign frac     = (div_rsp.q > DIV_N_W'(ONE_Q15)) ? ONE_Q15 : div_rsp.q[15:0];
  assign dser_new = (div_rsp.q > DIV_N_W'(ONE_Q15)) ? ONE_Q15 : div_rsp.q[15:0];
  assign x15      = {mul_rsp.p[30:0], 4'b0} - {4'b0, mul_rsp.p[30:0]};
  assign str_new  = (mul_rsp.p[40:32] != 9'd0) ? 16'hFFFF : mul_rsp.p[31:16];

  always_comb begin
    mul_fire = 1'b0;
    div_fire = 1'b0;
    case (state)
      ST_IDLE: mul_fire = in_ch.valid;
      ST_CA:   mul_fire = mul_rsp.done;
      ST_IP3A: div_fire = mul_rsp.done;
      ST_IP3D: mul_fire = div_rsp.done;
      ST_IP3R: mul_fire = mul_rsp.done;
      ST_ATPM: div_fire = mul_rsp.done;
      ST_ATPD: div_fire = div_rsp.done;
      ST_SCL: begin
        div_fire = div_rsp.done && req_valid && (ca_gt2 || ds_hit);
        mul_fire = div_rsp.done && req_valid && !ca_gt2 && !ds_hit;
      end
      ST_GLF:  mul_fire = div_rsp.done;
      ST_GLM:  div_fire = mul_rsp.done;
      ST_GLD: begin
        div_fire = div_rsp.done && ds_hit;
        mul_fire = div_rsp.done && !ds_hit;
      end
      ST_DS:   mul_fire = div_rsp.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= RST_BASELINE;
      dt         <= RST_TIME_STEP;
      retain     <= RST_IP3_RETAIN;
      target     <= RST_TARGET;
      covered    <= RST_COVERED;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASELINE:   base    <= cfg_data;
        REG_TIME_STEP:  dt      <= cfg_data;
        REG_IP3_RETAIN: retain  <= cfg_data;
        REG_TARGET:     target  <= cfg_data;
        REG_COVERED:    covered <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mul_req.go <= 1'b0;
      div_req.go <= 1'b0;
      o_valid    <= 1'b0;
      ca         <= RST_BASELINE;
      ip3        <= '0;
      atp        <= ONE_Q15;
      pool       <= ONE_Q15;
      tick       <= '0;
      last_spike <= '0;
    end else begin
      mul_req.go <= mul_fire;
      div_req.go <= div_fire;
      if (state == ST_DONE && (!o_valid || out_ch.ready)) o_valid <= 1'b1;
      else if (o_valid && out_ch.ready) o_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            stim       <= $signed(in_ch.stimulus);
            act        <= $signed(in_ch.activity_level);
            req_valid  <= in_ch.release_request && (in_ch.synapse_index < covered);
            strength   <= in_ch.synapse_strength;
            tick       <= tick + TICK_WIDTH'(1);
            mul_req.a  <= 25'(s_ca);
            mul_req.b  <= dt;
            state      <= ST_CA;
          end
        end
        ST_CA: begin
          if (mul_rsp.done) begin
            ca    <= ca_new;
            spike <= spike_hit;
            if (spike_hit) last_spike <= tick;
            if (stim_high) begin
              mul_req.a <= 25'(stim);
              mul_req.b <= dt;
              state     <= ST_IP3A;
            end else begin
              mul_req.a <= {10'b0, ip3};
              mul_req.b <= retain;
              state     <= ST_IP3R;
            end
          end
        end
        ST_IP3A: begin
          if (mul_rsp.done) begin
            div_req.n  <= {5'b0, mul_rsp.p[30:13]};
            div_req.d  <= DIV_BY_FIVE;
            state      <= ST_IP3D;
          end
        end
        ST_IP3D: begin
          if (div_rsp.done) begin
            mul_req.a  <= {10'b0, ip3_cap};
            mul_req.b  <= retain;
            state      <= ST_IP3R;
          end
        end
        ST_IP3R: begin
          if (mul_rsp.done) begin
            ip3        <= mul_rsp.p[30:16];
            mul_req.a  <= {atp_term[23], atp_term};
            mul_req.b  <= dt;
            state      <= ST_ATPM;
          end
        end
        ST_ATPM: begin
          if (mul_rsp.done) begin
            div_neg    <= atp_n[23];
            div_req.n  <= atp_n[23] ? ~atp_n[22:0] : atp_n[22:0];
            div_req.d  <= DIV_BY_FIVE;
            state      <= ST_ATPD;
          end
        end
        ST_ATPD: begin
          if (div_rsp.done) begin
            atp        <= atp_new;
            div_neg    <= sc_n2[23];
            div_req.n  <= sc_n2[23] ? ~sc_n2[22:0] : sc_n2[22:0];
            div_req.d  <= DIV_BY_TWENTYFIVE;
            state      <= ST_SCL;
          end
        end
        ST_SCL: begin
          if (div_rsp.done) begin
            scale <= scale_new;
            if (!req_valid) begin
              glu    <= '0;
              dser   <= '0;
              newstr <= strength;
              state  <= ST_DONE;
            end else if (ca_gt2) begin
              div_req.n  <= {1'b0, gf_diff, 5'b0};
              div_req.d  <= DIV_BY_FIVE;
              state      <= ST_GLF;
            end else begin
              glu <= '0;
              if (ds_hit) begin
                div_req.n  <= {2'b0, ds_diff, 4'b0};
                div_req.d  <= DIV_BY_THREE;
                state      <= ST_DS;
              end else begin
                dser       <= '0;
                mul_req.a  <= {8'b0, 1'b1, 16'd0};
                mul_req.b  <= strength;
                state      <= ST_STR;
              end
            end
          end
        end
        ST_GLF: begin
          if (div_rsp.done) begin
            mul_req.a  <= {9'b0, frac};
            mul_req.b  <= pool;
            state      <= ST_GLM;
          end
        end
        ST_GLM: begin
          if (mul_rsp.done) begin
            div_req.n  <= {5'b0, x15[34:17]};
            div_req.d  <= DIV_BY_TWENTYFIVE;
            state      <= ST_GLD;
          end
        end
        ST_GLD: begin
          if (div_rsp.done) begin
            glu  <= div_rsp.q[15:0];
            pool <= pool - div_rsp.q[15:0];
            if (ds_hit) begin
              div_req.n  <= {2'b0, ds_diff, 4'b0};
              div_req.d  <= DIV_BY_THREE;
              state      <= ST_DS;
            end else begin
              dser       <= '0;
              mul_req.a  <= {8'b0, 1'b1, div_rsp.q[15:0]};
              mul_req.b  <= strength;
              state      <= ST_STR;
            end
          end
        end
        ST_DS: begin
          if (div_rsp.done) begin
            dser       <= dser_new;
            mul_req.a  <= {8'b0, 1'b1, glu};
            mul_req.b  <= strength;
            state      <= ST_STR;
          end
        end
        ST_STR: begin
          if (mul_rsp.done) begin
            newstr <= str_new;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!o_valid || out_ch.ready) begin
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign last_ext = 64'(last_spike);

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!o_valid || out_ch.ready)) begin
      o_ca    <= ca;
      o_ip3   <= ip3;
      o_atp   <= atp;
      o_spike <= spike;
      o_tick  <= last_ext[31:0];
      o_glu   <= glu;
      o_dser  <= dser;
      o_str   <= newstr;
      o_scale <= scale;
    end
  end

  assign in_ch.ready             = (state == ST_IDLE);
  assign out_ch.valid            = o_valid;
  assign out_ch.calcium_level    = o_ca;
  assign out_ch.ip3_level        = o_ip3;
  assign out_ch.atp_out          = o_atp;
  assign out_ch.spike_flag       = o_spike;
  assign out_ch.spike_tick       = o_tick;
  assign out_ch.glutamate_amount = o_glu;
  assign out_ch.d_serine_amount  = o_dser;
  assign out_ch.new_strength     = o_str;
  assign out_ch.homeo_scale      = o_scale;
endmodule
`default_nettype wire

@@ tb/sv/tb_astrocyte_cell_dynamics_top.sv @@
// Self-checking testbench of the astrocyte cell dynamics block, with scoreboard and drivers.
`timescale 1ns / 100ps

module tb_astrocyte_cell_dynamics_top;
  import acd_pkg::*;

  typedef struct {
    logic [15:0] stimulus;
    logic [15:0] activity_level;
    logic        release_request;
    logic [15:0] synapse_index;
    logic [15:0] synapse_strength;
  } tick_in_t;

  typedef struct {
    logic [15:0] calcium_level;
    logic [14:0] ip3_level;
    logic [15:0] atp_out;
    logic        spike_flag;
    logic [31:0] spike_tick;
    logic [15:0] glutamate_amount;
    logic [15:0] d_serine_amount;
    logic [15:0] new_strength;
    logic [16:0] homeo_scale;
  } tick_out_t;

  class cell_scoreboard;
    longint    base, dt, retain, target, covered;
    longint    calcium, ip3, atp, pool;
    bit [31:0] ticks, spike_at;
    tick_out_t pending[$];
    int        errors;

    function new();
      base = longint'(RST_BASELINE);
      dt = longint'(RST_TIME_STEP);
      retain = longint'(RST_IP3_RETAIN);
      target = longint'(RST_TARGET);
      covered = longint'(RST_COVERED);
      calcium = longint'(RST_BASELINE);
      ip3 = 0;
      atp = longint'(ONE_Q15);
      pool = longint'(ONE_Q15);
      ticks = '0;
      spike_at = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_BASELINE: base = longint'(val);
        REG_TIME_STEP: dt = longint'(val);
        REG_IP3_RETAIN: retain = longint'(val);
        REG_TARGET: target = longint'(val);
        REG_COVERED: covered = longint'(val);
        default: ;
      endcase
    endfunction

    function longint fdiv(longint v, longint d);
      if (v >= 0) return v / d;
      return -((-v + d - 1) / d);
    endfunction

    function void note_input(tick_in_t it);
      longint    stim, act, frac, ds, ns, sc;
      tick_out_t r;
      stim = longint'(signed'(it.stimulus));
      act = longint'(signed'(it.activity_level));
      ticks = ticks + 32'd1;
      calcium = calcium + fdiv(dt * (2 * stim - 10 * (calcium - base)), 65536);
      if (calcium < 0) calcium = 0;
      if (calcium > CA_MAX) calcium = longint'(CA_MAX);
      if (stim > 2560) begin
        ip3 = ip3 + (dt * stim) / 40960;
        if (ip3 > IP3_MAX) ip3 = longint'(IP3_MAX);
      end
      ip3 = (ip3 * retain) >> 16;
      atp = atp + fdiv(dt * (163840 - 128 * act), 655360);
      if (atp < 0) atp = 0;
      if (atp > ONE_Q15) atp = longint'(ONE_Q15);
      r.spike_flag = calcium > 3 * base;
      if (r.spike_flag) spike_at = ticks;
      r.glutamate_amount = '0;
      r.d_serine_amount = '0;
      ns = longint'(it.synapse_strength);
      if (it.release_request && it.synapse_index < covered) begin
        if (calcium > 2 * base) begin
          frac = (calcium - 2 * base) * 32 / 5;
          if (frac > ONE_Q15) frac = longint'(ONE_Q15);
          frac = (frac * pool * 15) / (100 * 32768);
          pool = pool - frac;
          r.glutamate_amount = 16'(frac);
        end
        if (2 * calcium > 3 * base) begin
          ds = (2 * calcium - 3 * base) * 16 / 3;
          if (ds > ONE_Q15) ds = longint'(ONE_Q15);
          r.d_serine_amount = 16'(ds);
        end
        ns = (ns * (65536 + longint'(r.glutamate_amount))) >> 16;
        if (ns > 65535) ns = 65535;
      end
      sc = 32768 + fdiv(5 * target - 64 * calcium, 100);
      if (sc < SCALE_MIN) sc = longint'(SCALE_MIN);
      if (sc > SCALE_MAX) sc = longint'(SCALE_MAX);
      r.calcium_level = 16'(calcium);
      r.ip3_level = 15'(ip3);
      r.atp_out = 16'(atp);
      r.spike_tick = spike_at;
      r.new_strength = 16'(ns);
      r.homeo_scale = 17'(sc);
      pending.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(tick_out_t a);
      tick_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, calcium_level actual %0d", $time, a.calcium_level);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("calcium_level", longint'(e.calcium_level), longint'(a.calcium_level));
      cmp("ip3_level", longint'(e.ip3_level), longint'(a.ip3_level));
      cmp("atp_out", longint'(e.atp_out), longint'(a.atp_out));
      cmp("spike_flag", longint'(e.spike_flag), longint'(a.spike_flag));
      cmp("spike_tick", longint'(e.spike_tick), longint'(a.spike_tick));
      cmp("glutamate_amount", longint'(e.glutamate_amount), longint'(a.glutamate_amount));
      cmp("d_serine_amount", longint'(e.d_serine_amount), longint'(a.d_serine_amount));
      cmp("new_strength", longint'(e.new_strength), longint'(a.new_strength));
      cmp("homeo_scale", longint'(e.homeo_scale), longint'(a.homeo_scale));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BASELINE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    ready_mode = 0;
  int                    burst_left = 0;
  cell_scoreboard        sb = new();

  acd_in_if  in_ch ();
  acd_out_if out_ch ();

  astrocyte_cell_dynamics_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Receiver: ready follows a mode that changes now and then.
  always @(posedge clk) begin
    tick_out_t r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      r.calcium_level = out_ch.calcium_level;
      r.ip3_level = out_ch.ip3_level;
      r.atp_out = out_ch.atp_out;
      r.spike_flag = out_ch.spike_flag;
      r.spike_tick = out_ch.spike_tick;
      r.glutamate_amount = out_ch.glutamate_amount;
      r.d_serine_amount = out_ch.d_serine_amount;
      r.new_strength = out_ch.new_strength;
      r.homeo_scale = out_ch.homeo_scale;
      sb.check_result(r);
    end
    if ($urandom_range(0, 199) == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_all(int b, int d, int r, int t, int c);
    settle();
    write_reg(REG_BASELINE, 16'(b));
    write_reg(REG_TIME_STEP, 16'(d));
    write_reg(REG_IP3_RETAIN, 16'(r));
    write_reg(REG_TARGET, 16'(t));
    write_reg(REG_COVERED, 16'(c));
  endtask

  task automatic send(tick_in_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.stimulus <= it.stimulus;
    in_ch.activity_level <= it.activity_level;
    in_ch.release_request <= it.release_request;
    in_ch.synapse_index <= it.synapse_index;
    in_ch.synapse_strength <= it.synapse_strength;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  task automatic send_fields(int s, int a, bit q, int i, int g);
    tick_in_t it;
    it.stimulus = 16'(s);
    it.activity_level = 16'(a);
    it.release_request = q;
    it.synapse_index = 16'(i);
    it.synapse_strength = 16'(g);
    send(it);
  endtask

  task automatic send_random(int n);
    tick_in_t it;
    int       c;
    repeat (n) begin
      c = $urandom_range(0, 9);
      if (c < 4) it.stimulus = 16'($urandom());
      else if (c < 8) it.stimulus = 16'($urandom_range(0, 32767));
      else it.stimulus = 16'($urandom_range(0, 6000) - 3000);
      it.activity_level = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2048))
                                                      : 16'($urandom());
      it.release_request = ($urandom_range(0, 3) != 0);
      if (sb.covered > 0 && $urandom_range(0, 3) != 0)
        it.synapse_index = 16'($urandom_range(0, 32'(sb.covered - 1)));
      else
        it.synapse_index = 16'($urandom());
      it.synapse_strength = 16'($urandom());
      send(it);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.stimulus = '0;
    in_ch.activity_level = '0;
    in_ch.release_request = 1'b0;
    in_ch.synapse_index = '0;
    in_ch.synapse_strength = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_fields(0, 0, 1, 0, 256);
    send_fields(-32768, 32767, 0, 65535, 65535);
    send_fields(32767, -32768, 1, 0, 0);
    send_fields(2560, 256, 0, 0, 1);
    set_all(102, 6554, 65208, 19661, 4);
    send_fields(2561, 0, 1, 0, 256);
    send_fields(32767, -32768, 1, 3, 65535);
    send_fields(32767, 32767, 1, 0, 65535);
    send_fields(32767, 0, 1, 4, 1000);
    send_fields(32767, 0, 1, 65535, 1000);
    send_fields(-32768, 0, 1, 1, 512);
    send_fields(-32768, 32767, 1, 2, 0);
    send_fields(0, -1, 0, 0, 300);
    send_fields(-1, 1, 1, 3, 32768);
    set_all(0, 65535, 0, 0, 65535);
    send_fields(32767, 0, 1, 65534, 65535);
    send_fields(-32768, -32768, 1, 0, 65535);
    send_random(70);
    set_all(102, 6554, 65208, 19661, 8);
    send_random(80);
    set_all(51200, 65535, 65535, 65535, 1);
    send_random(60);
    set_all(512, 0, 65535, 65535, 100);
    send_random(40);
    set_all(2048, 20000, 40000, 30000, 16);
    send_random(80);
    set_all(65535, 1000, 65208, 100, 0);
    send_random(40);
    set_all(300, 12000, 50000, 40000, 65535);
    send_random(70);
    settle();
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
